>>> rtl/core/msq_pkg.sv
package msq_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_SERVERS_DEF = 16;
	localparam int TIME_BITS_DEF   = 32;

	// Fixed field widths of the channels.
	localparam int STAMP_BITS        = 32;
	localparam int SERVER_COUNT_BITS = 5;
	localparam int COUNT_BITS        = 32;
	localparam int OUT_COUNT_BITS    = 5;
	localparam int OUTCOME_BITS      = 2;
	localparam int CFG_INDEX_BITS    = 4;
	localparam int CFG_DATA_BITS     = 32;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SERVER_COUNT = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_QUEUE_MODE   = 4'd1;

	// Outcome codes of one arrival.
	localparam logic [OUTCOME_BITS-1:0] OUTCOME_SERVED  = 2'd0;
	localparam logic [OUTCOME_BITS-1:0] OUTCOME_WAITING = 2'd1;
	localparam logic [OUTCOME_BITS-1:0] OUTCOME_BLOCKED = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan_clear;
		logic scan_run;
		logic retire;
		logic arrive;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last;
		logic retire_due;
		logic out_free;
	} status_t;

endpackage

>>> rtl/core/msq_ctrl.sv
module msq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  msq_pkg::status_t status,
	output msq_pkg::cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_DECIDE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load       = 1'b1;
					cmd.scan_clear = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (status.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// The last slot read is compared in this cycle.
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (status.retire_due) begin
					cmd.retire     = 1'b1;
					cmd.scan_clear = 1'b1;
					state_d        = ST_SCAN;
				end else if (status.out_free) begin
					cmd.arrive = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/core/msq_dpath.sv
module msq_dpath #(
	parameter int MAX_SERVERS = msq_pkg::MAX_SERVERS_DEF,
	parameter int TIME_BITS   = msq_pkg::TIME_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  msq_pkg::cmd_t                        cmd,
	output msq_pkg::status_t                     status,
	input  logic [msq_pkg::STAMP_BITS-1:0]       arrival_stamp,
	input  logic [msq_pkg::STAMP_BITS-1:0]       service_length,
	input  logic                                 new_run,
	input  logic                                 clear_counts,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [msq_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [msq_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [msq_pkg::OUTCOME_BITS-1:0]     outcome,
	output logic [msq_pkg::COUNT_BITS-1:0]       arrival_total,
	output logic [msq_pkg::COUNT_BITS-1:0]       blocked_total,
	output logic [msq_pkg::OUT_COUNT_BITS-1:0]   busy_now,
	output logic [msq_pkg::OUT_COUNT_BITS-1:0]   waiting_now
);

	localparam int IW  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int CW  = $clog2(MAX_SERVERS + 1);
	localparam int TW  = CW + 1;
	localparam int SCW = msq_pkg::SERVER_COUNT_BITS;
	localparam int SW  = (CW > SCW) ? CW : SCW;
	localparam int WB  = (TIME_BITS > msq_pkg::STAMP_BITS) ? TIME_BITS : msq_pkg::STAMP_BITS;
	localparam int NB  = msq_pkg::COUNT_BITS;
	localparam int OB  = msq_pkg::OUT_COUNT_BITS;

	localparam logic [IW-1:0]        LAST_IDX = IW'(MAX_SERVERS - 1);
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	function automatic logic [TIME_BITS-1:0] time_add(input logic [TIME_BITS-1:0] a,
			input logic [TIME_BITS-1:0] b);
		logic [TIME_BITS:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
	endfunction

	// Configuration.
	logic [SCW-1:0] server_count_q;
	logic           queue_mode_q;

	// Current arrival.
	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] len_q;

	// Server and waiting-room state.
	logic [TIME_BITS-1:0]   fmem [MAX_SERVERS];
	logic [TIME_BITS-1:0]   wmem [MAX_SERVERS];
	logic [MAX_SERVERS-1:0] valid_q;
	logic [CW-1:0]          busy_q;
	logic [CW-1:0]          wcount_q;
	logic [IW-1:0]          head_q;
	logic [NB-1:0]          arr_q;
	logic [NB-1:0]          blk_q;
	logic [TIME_BITS-1:0]   wlen_q;

	// Minimum search.
	logic [IW-1:0]        scan_idx_q;
	logic                 rd_valid_s1;
	logic                 vbit_s1;
	logic [IW-1:0]        idx_s1;
	logic [TIME_BITS-1:0] rdata_s1;
	logic                 best_found_q;
	logic [IW-1:0]        best_idx_q;
	logic [TIME_BITS-1:0] best_time_q;
	logic                 free_found_q;
	logic [IW-1:0]        free_idx_q;

	// Result register.
	logic                    out_valid_q;
	logic [msq_pkg::OUTCOME_BITS-1:0] outcome_q;
	logic [NB-1:0]           arrival_total_q;
	logic [NB-1:0]           blocked_total_q;
	logic [OB-1:0]           busy_now_q;
	logic [OB-1:0]           waiting_now_q;

	logic [WB-1:0]        stamp_wide;
	logic [WB-1:0]        len_wide;
	logic [TIME_BITS-1:0] now_clip;
	logic [TIME_BITS-1:0] len_clip;
	logic [SW-1:0]        sc_wide;
	logic [SW-1:0]        s_wide;
	logic [CW-1:0]        s_active;
	logic [TW-1:0]        tail_sum;
	logic [TW-1:0]        tail_wrap;
	logic [IW-1:0]        tail_idx;
	logic [IW-1:0]        head_next;
	logic                 take_best;
	logic                 take_free;
	logic                 serve;
	logic                 queue;
	logic [NB-1:0]        arr_nx;
	logic [NB-1:0]        blk_nx;
	logic [CW-1:0]        busy_nx;
	logic [CW-1:0]        wcount_nx;
	logic [msq_pkg::OUTCOME_BITS-1:0] outcome_nx;
	logic                 fm_we;
	logic [IW-1:0]        fm_addr;
	logic [TIME_BITS-1:0] add_a;
	logic [TIME_BITS-1:0] add_b;
	logic [TIME_BITS-1:0] fm_wdata;

	// Input times saturate to the largest representable time.
	assign stamp_wide = WB'(arrival_stamp);
	assign len_wide   = WB'(service_length);
	assign now_clip   = (stamp_wide > WB'(TIME_MAX)) ? TIME_MAX : stamp_wide[TIME_BITS-1:0];
	assign len_clip   = (len_wide > WB'(TIME_MAX)) ? TIME_MAX : len_wide[TIME_BITS-1:0];

	// Servers in use, clamped to one through MAX_SERVERS.
	assign sc_wide  = SW'(server_count_q);
	assign s_wide   = (sc_wide == '0) ? SW'(1) :
			(sc_wide > SW'(MAX_SERVERS)) ? SW'(MAX_SERVERS) : sc_wide;
	assign s_active = s_wide[CW-1:0];

	// Waiting-room ring pointers.
	assign tail_sum  = TW'(head_q) + TW'(wcount_q);
	assign tail_wrap = (tail_sum >= TW'(MAX_SERVERS)) ? tail_sum - TW'(MAX_SERVERS) : tail_sum;
	assign tail_idx  = tail_wrap[IW-1:0];
	assign head_next = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;

	// Ascending scan with a strict compare keeps the lowest slot on ties.
	assign take_best = rd_valid_s1 && vbit_s1 && (!best_found_q || (rdata_s1 < best_time_q));
	assign take_free = rd_valid_s1 && !vbit_s1 && !free_found_q;

	assign serve      = (busy_q < s_active);
	assign queue      = !serve && queue_mode_q && (wcount_q < s_active);
	assign arr_nx     = (arr_q == '1) ? arr_q : arr_q + 1'b1;
	assign blk_nx     = (serve || queue || (blk_q == '1)) ? blk_q : blk_q + 1'b1;
	assign busy_nx    = serve ? busy_q + 1'b1 : busy_q;
	assign wcount_nx  = queue ? wcount_q + 1'b1 : wcount_q;
	assign outcome_nx = serve ? msq_pkg::OUTCOME_SERVED :
			queue ? msq_pkg::OUTCOME_WAITING : msq_pkg::OUTCOME_BLOCKED;

	// One shared adder for both finish-time writes.
	assign fm_we    = (cmd.retire && (wcount_q != '0)) || (cmd.arrive && serve);
	assign fm_addr  = cmd.retire ? best_idx_q : free_idx_q;
	assign add_a    = cmd.retire ? best_time_q : now_q;
	assign add_b    = cmd.retire ? wlen_q : len_q;
	assign fm_wdata = time_add(add_a, add_b);

	assign status.scan_last  = (scan_idx_q == LAST_IDX);
	assign status.retire_due = best_found_q && (best_time_q <= now_q);
	assign status.out_free   = !out_valid_q || out_ready;

	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign outcome       = outcome_q;
	assign arrival_total = arrival_total_q;
	assign blocked_total = blocked_total_q;
	assign busy_now      = busy_now_q;
	assign waiting_now   = waiting_now_q;

	always_ff @(posedge clk) begin
		if (fm_we) begin
			fmem[fm_addr] <= fm_wdata;
		end
		if (cmd.scan_run) begin
			rdata_s1 <= fmem[scan_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.arrive && queue) begin
			wmem[tail_idx] <= len_q;
		end
		wlen_q <= wmem[head_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q <= now_clip;
			len_q <= len_clip;
		end
		vbit_s1 <= valid_q[scan_idx_q];
		idx_s1  <= scan_idx_q;
		if (take_best) begin
			best_idx_q  <= idx_s1;
			best_time_q <= rdata_s1;
		end
		if (take_free) begin
			free_idx_q <= idx_s1;
		end
		if (cmd.arrive) begin
			outcome_q       <= outcome_nx;
			arrival_total_q <= arr_nx;
			blocked_total_q <= blk_nx;
			busy_now_q      <= OB'(busy_nx);
			waiting_now_q   <= OB'(wcount_nx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_count_q <= SCW'(1);
			queue_mode_q   <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				msq_pkg::CFG_SERVER_COUNT: server_count_q <= cfg_data[SCW-1:0];
				msq_pkg::CFG_QUEUE_MODE:   queue_mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q   <= '0;
			rd_valid_s1  <= 1'b0;
			best_found_q <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.scan_run;
			if (cmd.scan_clear) begin
				scan_idx_q   <= '0;
				best_found_q <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (cmd.scan_run && !status.scan_last) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				if (take_best) begin
					best_found_q <= 1'b1;
				end
				if (take_free) begin
					free_found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			busy_q      <= '0;
			wcount_q    <= '0;
			head_q      <= '0;
			arr_q       <= '0;
			blk_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result wins over the drain of the previous one.
			if (cmd.arrive) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load) begin
				if (new_run) begin
					valid_q  <= '0;
					busy_q   <= '0;
					wcount_q <= '0;
					head_q   <= '0;
				end
				if (clear_counts) begin
					arr_q <= '0;
					blk_q <= '0;
				end
			end else if (cmd.retire) begin
				if (wcount_q != '0) begin
					head_q   <= head_next;
					wcount_q <= wcount_q - 1'b1;
				end else begin
					valid_q[best_idx_q] <= 1'b0;
					if (busy_q != '0) begin
						busy_q <= busy_q - 1'b1;
					end
				end
			end else if (cmd.arrive) begin
				arr_q    <= arr_nx;
				blk_q    <= blk_nx;
				busy_q   <= busy_nx;
				wcount_q <= wcount_nx;
				if (serve) begin
					valid_q[free_idx_q] <= 1'b1;
				end
			end
		end
	end

endmodule

>>> rtl/core/multiserver_queue_event_sim_unit.sv
// Channel   Direction  Handshake              Contents
// in        input      in_valid / in_ready    arrival_stamp, service_length, new_run,
//                                             clear_counts
// out       output     out_valid / out_ready  outcome, arrival_total, blocked_total,
//                                             busy_now, waiting_now
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Between one input transaction and the next, the block runs one full scan of the
// finish-time memory per departure retired before the arrival, plus one more scan;
// each scan reads one slot per cycle and is followed by a drain and a decision step.
// Reset clears the server valid bits and all counters at once; there is
// no clearing pass. The finished result sits in an output register, so a new input
// transaction is taken while it waits; a later result holds in the decision step until
// the register is free.
module multiserver_queue_event_sim_unit #(
	parameter int MAX_SERVERS = msq_pkg::MAX_SERVERS_DEF,
	parameter int TIME_BITS   = msq_pkg::TIME_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [msq_pkg::STAMP_BITS-1:0]       arrival_stamp,
	input  logic [msq_pkg::STAMP_BITS-1:0]       service_length,
	input  logic                                 new_run,
	input  logic                                 clear_counts,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [msq_pkg::OUTCOME_BITS-1:0]     outcome,
	output logic [msq_pkg::COUNT_BITS-1:0]       arrival_total,
	output logic [msq_pkg::COUNT_BITS-1:0]       blocked_total,
	output logic [msq_pkg::OUT_COUNT_BITS-1:0]   busy_now,
	output logic [msq_pkg::OUT_COUNT_BITS-1:0]   waiting_now,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [msq_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [msq_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	// The controller sequences each arrival: load the transaction, scan all server
	// slots for the earliest pending departure, retire it if it is not later than
	// the arrival time and scan again, and finally place the arrival.
	msq_pkg::cmd_t    cmd;
	msq_pkg::status_t status;

	msq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the configuration, the finish-time and waiting-room
	// memories, the search registers, the counters and the result register.
	msq_dpath #(
		.MAX_SERVERS (MAX_SERVERS),
		.TIME_BITS   (TIME_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.arrival_stamp  (arrival_stamp),
		.service_length (service_length),
		.new_run        (new_run),
		.clear_counts   (clear_counts),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.outcome        (outcome),
		.arrival_total  (arrival_total),
		.blocked_total  (blocked_total),
		.busy_now       (busy_now),
		.waiting_now    (waiting_now)
	);

	// An accepted transaction keeps the block busy for at least the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted again right after a transaction");

	// An arrival is placed only when the result register can take it.
	a_arrive_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.arrive |-> status.out_free)
		else $error("arrival placed while result register is occupied");

	// Retiring a departure and placing the arrival never happen together.
	a_retire_or_arrive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.retire && cmd.arrive))
		else $error("retire and arrive issued in the same cycle");

	// A result appears only as the direct effect of placing an arrival.
	a_result_from_arrive: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.arrive))
		else $error("result shown without an arrival");

endmodule
